// ===== rtl/ctc_pkg.sv =====
// Shared constants for the characteristic trace cell: field widths,
// configuration register indexes and scheme codes.
// No dependencies.
package ctc_pkg;

    localparam int FIELD_W    = 32;
    localparam int IN_FIELDS  = 11;
    localparam int OUT_FIELDS = 10;
    localparam int TOC_W      = 18;
    localparam int MODE_W     = 2;
    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_TIME_OVER_CELL = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SCHEME_MODE    = 1'd1;

    localparam logic [MODE_W-1:0] MODE_MUSCL   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PLMDE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COLELLA = 2'd2;
    // unused code, decodes as Colella
    localparam logic [MODE_W-1:0] MODE_SPARE   = 2'd3;

    localparam logic [TOC_W-1:0] TOC_RESET = 18'd32768;

endpackage

// ===== rtl/characteristic_trace_cell_top.sv =====
// An input beat passes P1 to P8, three chained bit-per-stage dividers and the output
// register before it becomes a result beat.
// Throughput: one cell per cycle; the whole pipeline holds while the result waits.
// Reset (aresetn low, synchronous) clears all valid bits and loads
// time_over_cell = 32768 and scheme_mode = MUSCL-Hancock.
// Holds the pipelined datapath; depends on ctc_pkg and ctc_div.
module characteristic_trace_cell_top #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  logic                                              cfg_wr_en,
    input  logic [ctc_pkg::CFG_ADDR_W-1:0]                    cfg_addr,
    input  logic [ctc_pkg::TOC_W-1:0]                         cfg_wdata,
    input  logic                                              s_tvalid,
    output logic                                              s_tready,
    // density, normal_velocity, transverse_velocity, pressure, slope_density,
    // slope_normal_velocity, slope_transverse_velocity, slope_pressure,
    // sound_speed, passive_value, slope_passive (32 bit each, lowest first)
    input  logic [ctc_pkg::IN_FIELDS*ctc_pkg::FIELD_W-1:0]    s_tdata,
    output logic                                              m_tvalid,
    input  logic                                              m_tready,
    // right_density, right_normal_velocity, right_transverse_velocity,
    // right_pressure, right_passive, left_density, left_normal_velocity,
    // left_transverse_velocity, left_pressure, left_passive (32 bit each)
    output logic [ctc_pkg::OUT_FIELDS*ctc_pkg::FIELD_W-1:0]   m_tdata,
    // divide_fault
    output logic                                              m_tuser
);

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int FW = ctc_pkg::FIELD_W;

    typedef logic signed [W-1:0] word_t;

    localparam longint WMAX_L   = (longint'(1) <<< (W - 1)) - 1;
    localparam longint WMIN_L   = -WMAX_L - 1;
    localparam longint ONE_RAW  = longint'(1) <<< F;
    localparam longint HALF_RAW = longint'(1) <<< (F - 1);
    localparam longint HUND_RAW = longint'(100) <<< F;
    localparam word_t  WMAX     = W'(WMAX_L);
    localparam word_t  WMIN     = W'(WMIN_L);
    localparam word_t  ONE      = W'((ONE_RAW > WMAX_L) ? WMAX_L : ONE_RAW);
    localparam word_t  HALF     = W'((HALF_RAW > WMAX_L) ? WMAX_L : HALF_RAW);
    localparam word_t  HUNDRED  = W'((HUND_RAW > WMAX_L) ? WMAX_L : HUND_RAW);
    localparam logic [2*W-1:0] LIM_POS = {{(W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic [2*W-1:0] LIM_NEG = LIM_POS + {{(2*W - 1){1'b0}}, 1'b1};

    typedef struct packed {
        word_t r, u, v, p, dr, du, dv, dp, c, a, da;
    } cell_t;

    typedef struct packed {
        word_t r, u, v, p, dr, du, dv, c, a, da, csq, sm, sq;
    } d1_side_t;

    typedef struct packed {
        word_t r, u, v, p, dv, c, a, da, csq, sm, sq, a0r, tm, tp, pm, pp, pz;
        logic  f;
    } p3_t;

    typedef struct packed {
        word_t r, u, v, p, dv, c, a, da, csq, a0r, hm, hp;
        word_t [1:0] w_m, w_p, w_z;
        logic  f;
    } p4_t;

    typedef struct packed {
        word_t r, u, v, p, dv, c, a, da, csq, a0r;
        word_t [1:0] hw_m, hw_p, hw_z;
        logic  f;
    } d2_side_t;

    typedef struct packed {
        word_t r, u, v, p, c, a, csq;
        word_t [1:0] apv, amv, azr, azv, azp;
        logic  f;
    } p6_t;

    typedef struct packed {
        word_t r, u, p, c, csq;
        word_t [1:0] sa, df, s0, o2, o4;
        logic  f;
    } p7_t;

    typedef struct packed {
        word_t u, p;
        word_t [1:0] o0, o2, m3, o4;
        logic  f;
    } d3_side_t;

    // ---------------------------------------------------------------------
    // arithmetic helpers: saturating sums, truncating and saturating products
    function automatic word_t f_add(word_t a, word_t b);
        logic [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1]) begin
            return s[W] ? WMIN : WMAX;
        end
        return s[W-1:0];
    endfunction

    function automatic word_t f_sub(word_t a, word_t b);
        logic [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1]) begin
            return s[W] ? WMIN : WMAX;
        end
        return s[W-1:0];
    endfunction

    function automatic word_t f_neg(word_t a);
        return (a == WMIN) ? WMAX : (~a + 1'b1);
    endfunction

    function automatic word_t f_mul(word_t a, word_t b);
        logic [W-1:0]   ma;
        logic [W-1:0]   mb;
        logic [2*W-1:0] prod;
        logic [2*W-1:0] sh;
        ma   = a[W-1] ? (~a + 1'b1) : a;
        mb   = b[W-1] ? (~b + 1'b1) : b;
        prod = ma * mb;
        sh   = prod >> F;
        if (a[W-1] ^ b[W-1]) begin
            if (sh > LIM_NEG) begin
                sh = LIM_NEG;
            end
            return ~sh[W-1:0] + 1'b1;
        end
        if (sh > LIM_POS) begin
            sh = LIM_POS;
        end
        return sh[W-1:0];
    endfunction

    function automatic word_t f_in(logic [FW-1:0] x);
        longint xl;
        xl = longint'(signed'(x));
        if (xl > WMAX_L) begin
            xl = WMAX_L;
        end
        if (xl < WMIN_L) begin
            xl = WMIN_L;
        end
        return W'(xl);
    endfunction

    function automatic logic [FW-1:0] f_out(word_t a);
        longint al;
        al = longint'(a);
        if (al > longint'(32'sh7fff_ffff)) begin
            al = longint'(32'sh7fff_ffff);
        end
        if (al < -longint'(32'sh7fff_ffff) - 1) begin
            al = -longint'(32'sh7fff_ffff) - 1;
        end
        return FW'(al);
    endfunction

    // weight of one wave: projection constant when it points the wrong way
    function automatic word_t f_weight(word_t speed, word_t prod, logic left,
                                       word_t thr, word_t proj, logic muscl);
        word_t test;
        test = muscl ? prod : speed;
        if (!left) begin
            return (test >= thr) ? proj : f_add(prod, ONE);
        end
        return (test <= f_neg(thr)) ? f_neg(proj) : f_sub(prod, ONE);
    endfunction

    // ---------------------------------------------------------------------
    // configuration
    logic [ctc_pkg::TOC_W-1:0]  toc_reg;
    logic [ctc_pkg::MODE_W-1:0] mode_reg;
    word_t                      dtdx;
    word_t                      thr;
    word_t                      proj;
    logic                       muscl;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            toc_reg  <= ctc_pkg::TOC_RESET;
            mode_reg <= ctc_pkg::MODE_MUSCL;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                ctc_pkg::REG_TIME_OVER_CELL: toc_reg  <= cfg_wdata;
                ctc_pkg::REG_SCHEME_MODE:    mode_reg <= cfg_wdata[ctc_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    assign dtdx  = (longint'(toc_reg) > WMAX_L) ? WMAX : W'(toc_reg);
    assign muscl = (mode_reg == ctc_pkg::MODE_MUSCL);

    always_comb begin
        unique case (mode_reg)
            ctc_pkg::MODE_MUSCL: begin
                thr  = HUNDRED;
                proj = ONE;
            end
            ctc_pkg::MODE_PLMDE: begin
                thr  = '0;
                proj = ONE;
            end
            ctc_pkg::MODE_COLELLA: begin
                thr  = '0;
                proj = '0;
            end
            default: begin
                // unused code behaves as Colella
                thr  = '0;
                proj = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // pipeline control: everything advances together unless the result is held
    logic en;
    logic p1_vld_reg, p2_vld_reg, p3_vld_reg, p4_vld_reg, p5_vld_reg;
    logic p6_vld_reg, p7_vld_reg, p8_vld_reg, m_valid_reg;
    logic d1_vld, d2_vld, d3_vld;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            p3_vld_reg  <= 1'b0;
            p4_vld_reg  <= 1'b0;
            p5_vld_reg  <= 1'b0;
            p6_vld_reg  <= 1'b0;
            p7_vld_reg  <= 1'b0;
            p8_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            p1_vld_reg  <= s_tvalid;
            p2_vld_reg  <= p1_vld_reg;
            p3_vld_reg  <= d1_vld;
            p4_vld_reg  <= p3_vld_reg;
            p5_vld_reg  <= p4_vld_reg;
            p6_vld_reg  <= d2_vld;
            p7_vld_reg  <= p6_vld_reg;
            p8_vld_reg  <= p7_vld_reg;
            m_valid_reg <= d3_vld;
        end
    end

    // ---------------------------------------------------------------------
    // P1: bring fields to the word
    cell_t p1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg.r  <= f_in(s_tdata[0*FW +: FW]);
            p1_reg.u  <= f_in(s_tdata[1*FW +: FW]);
            p1_reg.v  <= f_in(s_tdata[2*FW +: FW]);
            p1_reg.p  <= f_in(s_tdata[3*FW +: FW]);
            p1_reg.dr <= f_in(s_tdata[4*FW +: FW]);
            p1_reg.du <= f_in(s_tdata[5*FW +: FW]);
            p1_reg.dv <= f_in(s_tdata[6*FW +: FW]);
            p1_reg.dp <= f_in(s_tdata[7*FW +: FW]);
            p1_reg.c  <= f_in(s_tdata[8*FW +: FW]);
            p1_reg.a  <= f_in(s_tdata[9*FW +: FW]);
            p1_reg.da <= f_in(s_tdata[10*FW +: FW]);
        end
    end

    // P2: r*c, c*c and the two acoustic speeds
    d1_side_t p2_side_reg;
    word_t    p2_dp_reg;
    word_t    p2_rc_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_side_reg.r   <= p1_reg.r;
            p2_side_reg.u   <= p1_reg.u;
            p2_side_reg.v   <= p1_reg.v;
            p2_side_reg.p   <= p1_reg.p;
            p2_side_reg.dr  <= p1_reg.dr;
            p2_side_reg.du  <= p1_reg.du;
            p2_side_reg.dv  <= p1_reg.dv;
            p2_side_reg.c   <= p1_reg.c;
            p2_side_reg.a   <= p1_reg.a;
            p2_side_reg.da  <= p1_reg.da;
            p2_side_reg.csq <= f_mul(p1_reg.c, p1_reg.c);
            p2_side_reg.sm  <= f_sub(p1_reg.u, p1_reg.c);
            p2_side_reg.sq  <= f_add(p1_reg.u, p1_reg.c);
            p2_dp_reg       <= p1_reg.dp;
            p2_rc_reg       <= f_mul(p1_reg.r, p1_reg.c);
        end
    end

    // first divider: dp/(r c) and dp/c^2
    logic [1:0][W-1:0] d1_q;
    logic              d1_fault;
    d1_side_t          d1_side;

    ctc_div #(
        .W      (W),
        .F      (F),
        .LANES  (2),
        .SIDE_W ($bits(d1_side_t))
    ) u_div1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p2_vld_reg),
        .num       ({p2_dp_reg, p2_dp_reg}),
        .den       ({p2_side_reg.csq, p2_rc_reg}),
        .side_in   (p2_side_reg),
        .out_valid (d1_vld),
        .quot      (d1_q),
        .fault     (d1_fault),
        .side_out  (d1_side)
    );

    // P3: entropy amplitude, t -/+ du, speed products
    p3_t p3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p3_reg.r   <= d1_side.r;
            p3_reg.u   <= d1_side.u;
            p3_reg.v   <= d1_side.v;
            p3_reg.p   <= d1_side.p;
            p3_reg.dv  <= d1_side.dv;
            p3_reg.c   <= d1_side.c;
            p3_reg.a   <= d1_side.a;
            p3_reg.da  <= d1_side.da;
            p3_reg.csq <= d1_side.csq;
            p3_reg.sm  <= d1_side.sm;
            p3_reg.sq  <= d1_side.sq;
            p3_reg.a0r <= f_sub(d1_side.dr, d1_q[1]);
            p3_reg.tm  <= f_sub(d1_q[0], d1_side.du);
            p3_reg.tp  <= f_add(d1_q[0], d1_side.du);
            p3_reg.pm  <= f_mul(d1_side.sm, dtdx);
            p3_reg.pp  <= f_mul(d1_side.sq, dtdx);
            p3_reg.pz  <= f_mul(d1_side.u, dtdx);
            p3_reg.f   <= d1_fault;
        end
    end

    // P4: halve the acoustic terms, pick the wave weights (0 right, 1 left)
    p4_t p4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p4_reg.r   <= p3_reg.r;
            p4_reg.u   <= p3_reg.u;
            p4_reg.v   <= p3_reg.v;
            p4_reg.p   <= p3_reg.p;
            p4_reg.dv  <= p3_reg.dv;
            p4_reg.c   <= p3_reg.c;
            p4_reg.a   <= p3_reg.a;
            p4_reg.da  <= p3_reg.da;
            p4_reg.csq <= p3_reg.csq;
            p4_reg.a0r <= p3_reg.a0r;
            p4_reg.hm  <= f_mul(HALF, p3_reg.tm);
            p4_reg.hp  <= f_mul(HALF, p3_reg.tp);
            for (int d = 0; d < 2; d++) begin
                p4_reg.w_m[d] <= f_weight(p3_reg.sm, p3_reg.pm, d[0], thr, proj, muscl);
                p4_reg.w_p[d] <= f_weight(p3_reg.sq, p3_reg.pp, d[0], thr, proj, muscl);
                p4_reg.w_z[d] <= f_weight(p3_reg.u, p3_reg.pz, d[0], thr, proj, muscl);
            end
            p4_reg.f   <= p3_reg.f;
        end
    end

    // P5: scale by density, halve the weights
    d2_side_t p5_side_reg;
    word_t    p5_xm_reg;
    word_t    p5_xp_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p5_side_reg.r   <= p4_reg.r;
            p5_side_reg.u   <= p4_reg.u;
            p5_side_reg.v   <= p4_reg.v;
            p5_side_reg.p   <= p4_reg.p;
            p5_side_reg.dv  <= p4_reg.dv;
            p5_side_reg.c   <= p4_reg.c;
            p5_side_reg.a   <= p4_reg.a;
            p5_side_reg.da  <= p4_reg.da;
            p5_side_reg.csq <= p4_reg.csq;
            p5_side_reg.a0r <= p4_reg.a0r;
            for (int d = 0; d < 2; d++) begin
                p5_side_reg.hw_m[d] <= f_mul(HALF, p4_reg.w_m[d]);
                p5_side_reg.hw_p[d] <= f_mul(HALF, p4_reg.w_p[d]);
                p5_side_reg.hw_z[d] <= f_mul(HALF, p4_reg.w_z[d]);
            end
            p5_side_reg.f   <= p4_reg.f;
            p5_xm_reg       <= f_mul(p4_reg.hm, p4_reg.r);
            p5_xp_reg       <= f_mul(p4_reg.hp, p4_reg.r);
        end
    end

    // second divider: acoustic amplitudes over c
    logic [1:0][W-1:0] d2_q;
    logic              d2_fault;
    d2_side_t          d2_side;

    ctc_div #(
        .W      (W),
        .F      (F),
        .LANES  (2),
        .SIDE_W ($bits(d2_side_t))
    ) u_div2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p5_vld_reg),
        .num       ({p5_xp_reg, p5_xm_reg}),
        .den       ({p5_side_reg.c, p5_side_reg.c}),
        .side_in   (p5_side_reg),
        .out_valid (d2_vld),
        .quot      (d2_q),
        .fault     (d2_fault),
        .side_out  (d2_side)
    );

    // P6: projected wave contributions
    p6_t p6_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p6_reg.r   <= d2_side.r;
            p6_reg.u   <= d2_side.u;
            p6_reg.v   <= d2_side.v;
            p6_reg.p   <= d2_side.p;
            p6_reg.c   <= d2_side.c;
            p6_reg.a   <= d2_side.a;
            p6_reg.csq <= d2_side.csq;
            for (int d = 0; d < 2; d++) begin
                p6_reg.apv[d] <= f_neg(f_mul(d2_side.hw_p[d], d2_q[1]));
                p6_reg.amv[d] <= f_neg(f_mul(d2_side.hw_m[d], d2_q[0]));
                p6_reg.azr[d] <= f_neg(f_mul(d2_side.hw_z[d], d2_side.a0r));
                p6_reg.azv[d] <= f_neg(f_mul(d2_side.hw_z[d], d2_side.dv));
                p6_reg.azp[d] <= f_neg(f_mul(d2_side.hw_z[d], d2_side.da));
            end
            p6_reg.f   <= d2_side.f | d2_fault;
        end
    end

    // P7: sums and differences of the contributions
    p7_t p7_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p7_reg.r   <= p6_reg.r;
            p7_reg.u   <= p6_reg.u;
            p7_reg.p   <= p6_reg.p;
            p7_reg.c   <= p6_reg.c;
            p7_reg.csq <= p6_reg.csq;
            for (int d = 0; d < 2; d++) begin
                p7_reg.sa[d] <= f_add(p6_reg.apv[d], p6_reg.amv[d]);
                p7_reg.df[d] <= f_sub(p6_reg.apv[d], p6_reg.amv[d]);
                p7_reg.s0[d] <= f_add(f_add(p6_reg.apv[d], p6_reg.amv[d]), p6_reg.azr[d]);
                p7_reg.o2[d] <= f_add(p6_reg.v, p6_reg.azv[d]);
                p7_reg.o4[d] <= f_add(p6_reg.a, p6_reg.azp[d]);
            end
            p7_reg.f   <= p6_reg.f;
        end
    end

    // P8: density result, pressure and velocity products
    d3_side_t          p8_side_reg;
    word_t [1:0]       p8_nd_reg;
    word_t             p8_r_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p8_side_reg.u <= p7_reg.u;
            p8_side_reg.p <= p7_reg.p;
            for (int d = 0; d < 2; d++) begin
                p8_side_reg.o0[d] <= f_add(p7_reg.r, p7_reg.s0[d]);
                p8_side_reg.o2[d] <= p7_reg.o2[d];
                p8_side_reg.m3[d] <= f_mul(p7_reg.sa[d], p7_reg.csq);
                p8_side_reg.o4[d] <= p7_reg.o4[d];
                p8_nd_reg[d]      <= f_mul(p7_reg.df[d], p7_reg.c);
            end
            p8_side_reg.f <= p7_reg.f;
            p8_r_reg      <= p7_reg.r;
        end
    end

    // third divider: normal velocity correction over density
    logic [1:0][W-1:0] d3_q;
    logic              d3_fault;
    d3_side_t          d3_side;

    ctc_div #(
        .W      (W),
        .F      (F),
        .LANES  (2),
        .SIDE_W ($bits(d3_side_t))
    ) u_div3 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p8_vld_reg),
        .num       ({p8_nd_reg[1], p8_nd_reg[0]}),
        .den       ({p8_r_reg, p8_r_reg}),
        .side_in   (p8_side_reg),
        .out_valid (d3_vld),
        .quot      (d3_q),
        .fault     (d3_fault),
        .side_out  (d3_side)
    );

    // output register: finish velocity and pressure, clamp to 32 bit
    logic [ctc_pkg::OUT_FIELDS*FW-1:0] m_data_reg;
    logic                              m_user_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int d = 0; d < 2; d++) begin
                m_data_reg[(5*d + 0)*FW +: FW] <= f_out(d3_side.o0[d]);
                m_data_reg[(5*d + 1)*FW +: FW] <= f_out(f_add(d3_side.u, d3_q[d]));
                m_data_reg[(5*d + 2)*FW +: FW] <= f_out(d3_side.o2[d]);
                m_data_reg[(5*d + 3)*FW +: FW] <= f_out(f_add(d3_side.p, d3_side.m3[d]));
                m_data_reg[(5*d + 4)*FW +: FW] <= f_out(d3_side.o4[d]);
            end
            m_user_reg <= d3_side.f | d3_fault;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef SYNTHESIS
    a_reset_empties: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_beat_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> p1_vld_reg)
        else $error("accepted beat missing from first stage");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |=> $stable(p1_vld_reg) && $stable(p5_vld_reg) && $stable(p8_vld_reg))
        else $error("pipeline moved while stalled");
`endif

endmodule

// ===== rtl/ctc_div.sv =====
// Pipelined restoring divider for signed fixed point words, one quotient
// bit per stage, several lanes sharing one valid and one sideband word.
// Standalone; instantiated by characteristic_trace_cell_top.
module ctc_div #(
    parameter int W      = 32,
    parameter int F      = 16,
    parameter int LANES  = 2,
    parameter int SIDE_W = 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [LANES-1:0][W-1:0] num,
    input  logic [LANES-1:0][W-1:0] den,
    input  logic [SIDE_W-1:0]       side_in,
    output logic                    out_valid,
    output logic [LANES-1:0][W-1:0] quot,
    output logic                    fault,
    output logic [SIDE_W-1:0]       side_out
);

    localparam int QW    = W + F;
    localparam int STEPS = W + F;
    localparam logic [QW-1:0] POS_LIM = {{(F + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic [QW-1:0] NEG_LIM = POS_LIM + {{(QW - 1){1'b0}}, 1'b1};
    localparam logic [W-1:0]  WMAX    = {1'b0, {(W - 1){1'b1}}};
    localparam logic [W-1:0]  WMIN    = {1'b1, {(W - 1){1'b0}}};

    logic              vld_reg  [0:STEPS];
    logic [SIDE_W-1:0] side_reg [0:STEPS];
    logic [W-1:0]      nmag_reg [0:STEPS][0:LANES-1];
    logic [W-1:0]      dmag_reg [0:STEPS][0:LANES-1];
    logic [W-1:0]      rem_reg  [0:STEPS][0:LANES-1];
    logic [QW-1:0]     quo_reg  [0:STEPS][0:LANES-1];
    logic              neg_reg  [0:STEPS][0:LANES-1];
    logic              dz_reg   [0:STEPS][0:LANES-1];
    logic              nz_reg   [0:STEPS][0:LANES-1];

    logic                    out_vld_reg;
    logic [LANES-1:0][W-1:0] quot_reg;
    logic                    fault_reg;
    logic [SIDE_W-1:0]       side_out_reg;
    logic [LANES-1:0][W-1:0] quot_next;
    logic                    fault_next;

    // entry stage: magnitudes and result sign
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_entry
        always_ff @(posedge aclk) begin
            if (en) begin
                nmag_reg[0][l] <= num[l][W-1] ? (~num[l] + 1'b1) : num[l];
                dmag_reg[0][l] <= den[l][W-1] ? (~den[l] + 1'b1) : den[l];
                rem_reg[0][l]  <= '0;
                quo_reg[0][l]  <= '0;
                dz_reg[0][l]   <= (den[l] == '0);
                nz_reg[0][l]   <= (num[l] != '0);
                // a zero divisor takes the sign of the numerator alone
                neg_reg[0][l]  <= (den[l] == '0) ? num[l][W-1] : (num[l][W-1] ^ den[l][W-1]);
            end
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam int BIT_POS = STEPS - 1 - k;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k+1] <= side_reg[k];
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic       num_bit;
            logic [W:0] trial;
            logic       fits;

            if (BIT_POS >= F) begin : g_num
                assign num_bit = nmag_reg[k][l][BIT_POS-F];
            end else begin : g_pad
                assign num_bit = 1'b0;
            end

            assign trial = {rem_reg[k][l], num_bit};
            assign fits  = (trial >= {1'b0, dmag_reg[k][l]});

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k+1][l]  <= fits ? W'(trial - {1'b0, dmag_reg[k][l]}) : trial[W-1:0];
                    quo_reg[k+1][l]  <= {quo_reg[k][l][QW-2:0], fits};
                    nmag_reg[k+1][l] <= nmag_reg[k][l];
                    dmag_reg[k+1][l] <= dmag_reg[k][l];
                    neg_reg[k+1][l]  <= neg_reg[k][l];
                    dz_reg[k+1][l]   <= dz_reg[k][l];
                    nz_reg[k+1][l]   <= nz_reg[k][l];
                end
            end
        end
    end

    // saturate the quotient to the word, flag a zero divisor
    always_comb begin
        logic [QW-1:0] mq;
        fault_next = 1'b0;
        for (int l = 0; l < LANES; l++) begin
            mq = quo_reg[STEPS][l];
            if (dz_reg[STEPS][l]) begin
                fault_next   = 1'b1;
                quot_next[l] = !nz_reg[STEPS][l] ? '0 : (neg_reg[STEPS][l] ? WMIN : WMAX);
            end else if (neg_reg[STEPS][l]) begin
                if (mq > NEG_LIM) begin
                    mq = NEG_LIM;
                end
                quot_next[l] = ~mq[W-1:0] + 1'b1;
            end else begin
                if (mq > POS_LIM) begin
                    mq = POS_LIM;
                end
                quot_next[l] = mq[W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= vld_reg[STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quot_reg     <= quot_next;
            fault_reg    <= fault_next;
            side_out_reg <= side_reg[STEPS];
        end
    end

    assign out_valid = out_vld_reg;
    assign quot      = quot_reg;
    assign fault     = fault_reg;
    assign side_out  = side_out_reg;

endmodule
